/* rtl/gaps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gaps_pkg;

    localparam int COORD_W = 5;

    // Commands.
    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_OBSTACLE = 2'd1;
    localparam logic [1:0] CMD_SEARCH   = 2'd2;
    localparam logic [1:0] CMD_READ     = 2'd3;

    // Cell status codes.
    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_OPEN     = 2'd1;
    localparam logic [1:0] ST_CLOSED   = 2'd2;
    localparam logic [1:0] ST_OBSTACLE = 2'd3;

    // Predecessor direction codes.
    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_LEFT  = 3'd1;
    localparam logic [2:0] DIR_RIGHT = 3'd2;
    localparam logic [2:0] DIR_UP    = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;

    localparam logic [10:0] COST_INF = 11'd1024;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_y;
    } t_in_beat;

    typedef struct packed {
        logic        found;
        logic [9:0]  path_cost;
        logic [1:0]  cell_status;
        logic [10:0] cell_cost;
        logic [2:0]  from_dir;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,      // sweep over cells
        S_OPEN_RD,  // read start cell
        S_OPEN_CHK,
        S_SCAN_RD,  // scan the open list for minimum f
        S_SCAN,
        S_SHIFT_RD, // close the gap at the chosen entry
        S_SHIFT_WR,
        S_POP_RD,   // read popped cell
        S_POP_CHK,
        S_NB_RD,    // read one neighbour
        S_NB_CHK,
        S_RD_WAIT,
        S_RD_OUT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* rtl/gaps_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/grid_astar_path_search_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports                          | Beat
// command | i_start, o_busy, i_cmd_beat    | t_in_beat, taken when start and not busy
// result  | o_strobe, o_res_beat           | t_out_beat, valid for one cycle
// Clear keeps busy high for a sweep of the cell memory at one cell a cycle. A search
// takes that sweep and then, per pop, a scan of the open list, a shift that closes the
// gap at the chosen entry and a read and check per neighbour; the open-list memory,
// with one read and one write a cycle, sets this. After reset the block first sweeps
// the cell memory with busy high. The receiver cannot stall results.
module grid_astar_path_search_top #(
    parameter int GRID_W     = 32,
    parameter int GRID_H     = 32,
    parameter int OPEN_DEPTH = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire gaps_pkg::t_in_beat i_cmd_beat,
    output logic                    o_busy,
    output logic                    o_strobe,
    output gaps_pkg::t_out_beat     o_res_beat
);
    import gaps_pkg::*;

    localparam int CELLS = GRID_W * GRID_H;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YW    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int OW    = $clog2(OPEN_DEPTH);
    localparam int CW    = OW + 1;
    localparam int FW    = 12;
    localparam int EW    = FW + XW + YW;
    // Cell word: blocked, status, parent, cost.
    localparam int CELLW = 1 + 2 + 3 + 11;

    // Cell memory.
    logic             c_we;
    logic [AW-1:0]    c_waddr, c_raddr;
    logic [CELLW-1:0] c_wdata, c_rdata;
    // Open-list memory.
    logic             o_we;
    logic [OW-1:0]    o_waddr, o_raddr;
    logic [EW-1:0]    o_wdata, o_rdata;

    gaps_ram #(.WIDTH(CELLW), .DEPTH(CELLS)) u_cells (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
    gaps_ram #(.WIDTH(EW), .DEPTH(OPEN_DEPTH)) u_open (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_raddr(o_raddr), .o_rdata(o_rdata)
    );

    t_state       r_state, n_state;
    logic         r_boot, n_boot;
    logic         r_keep, n_keep;       // sweep keeps obstacles (search)
    t_in_beat     r_cmd, n_cmd;
    logic [AW:0]  r_addr, n_addr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [OW-1:0] r_best, n_best;
    logic [FW-1:0] r_bf, n_bf;
    logic [XW+YW-1:0] r_bcell, n_bcell; // row and column of the chosen entry
    logic [AW-1:0] r_cur, n_cur;
    logic [10:0]  r_gcur, n_gcur;
    logic [2:0]   r_d, n_d;
    logic [AW-1:0] r_nb, n_nb;
    logic [XW-1:0] r_nx, n_nx;
    logic [YW-1:0] r_ny, n_ny;
    logic         r_strobe, n_strobe;
    t_out_beat    r_res, n_res;

    // Unpacked view of the cell word read back.
    logic        rd_blk;
    logic [1:0]  rd_st;
    logic [2:0]  rd_par;
    logic [10:0] rd_cost;
    assign {rd_blk, rd_st, rd_par, rd_cost} = c_rdata;

    logic          in_grid, goal_in;
    logic [AW-1:0] cell_idx, goal_idx;
    logic [XW-1:0] cur_x;
    logic [YW-1:0] cur_y;
    logic [FW-1:0] e_f;
    logic [XW+YW-1:0] e_cell;
    logic [11:0]   g1;
    logic [FW-1:0] hx, hy;

    assign in_grid  = ({27'd0, r_cmd.cell_x} < 32'(GRID_W)) &&
                      ({27'd0, r_cmd.cell_y} < 32'(GRID_H));
    assign goal_in  = ({27'd0, r_cmd.goal_x} < 32'(GRID_W)) &&
                      ({27'd0, r_cmd.goal_y} < 32'(GRID_H));
    assign cell_idx = AW'(32'(r_cmd.cell_y) * GRID_W + 32'(r_cmd.cell_x));
    assign goal_idx = AW'(32'(r_cmd.goal_y) * GRID_W + 32'(r_cmd.goal_x));
    // The popped entry carries its own row and column.
    assign cur_x    = r_bcell[XW-1:0];
    assign cur_y    = r_bcell[XW+YW-1:XW];
    assign {e_f, e_cell} = o_rdata;
    assign g1 = {1'b0, r_gcur} + 12'd1;
    assign hx = (FW'(r_nx) > FW'(r_cmd.goal_x)) ? FW'(r_nx) - FW'(r_cmd.goal_x)
                                                : FW'(r_cmd.goal_x) - FW'(r_nx);
    assign hy = (FW'(r_ny) > FW'(r_cmd.goal_y)) ? FW'(r_ny) - FW'(r_cmd.goal_y)
                                                : FW'(r_cmd.goal_y) - FW'(r_ny);

    // State and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_boot   <= 1'b1;
            r_keep   <= 1'b0;
            r_addr   <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_boot   <= n_boot;
            r_keep   <= n_keep;
            r_addr   <= n_addr;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_best  <= n_best;
        r_bf    <= n_bf;
        r_bcell <= n_bcell;
        r_cur   <= n_cur;
        r_gcur  <= n_gcur;
        r_d     <= n_d;
        r_nb    <= n_nb;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_res   <= n_res;
    end

    // Sequencer.
    always_comb begin
        n_state = r_state; n_boot = r_boot; n_keep = r_keep; n_cmd = r_cmd;
        n_addr = r_addr; n_cnt = r_cnt; n_idx = r_idx; n_best = r_best;
        n_bf = r_bf; n_bcell = r_bcell; n_cur = r_cur; n_gcur = r_gcur;
        n_d = r_d; n_nb = r_nb; n_nx = r_nx; n_ny = r_ny;
        n_strobe = 1'b0; n_res = r_res;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd = i_cmd_beat;
                    n_res = '0;
                    n_addr = '0;
                    case (i_cmd_beat.cmd)
                        CMD_CLEAR:    begin n_keep = 1'b0; n_state = S_CLR; end
                        CMD_SEARCH:   begin n_keep = 1'b1; n_state = S_CLR; end
                        CMD_OBSTACLE: n_state = S_DONE;
                        CMD_READ:     n_state = S_RD_WAIT;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_CLR: begin
                // Read-modify-write sweep: read ahead one cell, write the one behind.
                c_raddr = (r_addr < (AW+1)'(CELLS)) ? r_addr[AW-1:0] : '0;
                if (r_addr != '0) begin
                    c_waddr = AW'(r_addr - 1'b1);
                    if (r_keep && rd_blk) begin
                        c_we = 1'b0;
                    end else begin
                        c_we = 1'b1;
                        c_wdata = {1'b0, ST_UNKNOWN, DIR_NONE, COST_INF};
                    end
                    if (!r_keep) c_we = 1'b1;
                end
                n_addr = r_addr + 1'b1;
                if (r_addr == (AW+1)'(CELLS)) begin
                    n_cnt = '0;
                    if (r_boot) begin
                        n_boot = 1'b0;
                        n_state = S_IDLE;
                    end else if (!r_keep) begin
                        n_state = S_DONE;
                    end else if (!in_grid || !goal_in) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_OPEN_RD;
                    end
                end
            end
            S_OPEN_RD: begin
                c_raddr = cell_idx;
                n_state = S_OPEN_CHK;
            end
            S_OPEN_CHK: begin
                if (rd_blk) begin
                    n_state = S_DONE;
                end else begin
                    c_we = 1'b1; c_waddr = cell_idx;
                    c_wdata = {1'b0, ST_UNKNOWN, DIR_NONE, 11'd0};
                    n_nx = XW'(r_cmd.cell_x); n_ny = YW'(r_cmd.cell_y);
                    n_gcur = '0;
                    o_we = 1'b1; o_waddr = '0;
                    o_wdata = {FW'(FW'(r_cmd.cell_x > r_cmd.goal_x ?
                                r_cmd.cell_x - r_cmd.goal_x : r_cmd.goal_x - r_cmd.cell_x)
                              + FW'(r_cmd.cell_y > r_cmd.goal_y ?
                                r_cmd.cell_y - r_cmd.goal_y : r_cmd.goal_y - r_cmd.cell_y)),
                               YW'(r_cmd.cell_y), XW'(r_cmd.cell_x)};
                    n_cnt = CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    o_raddr = '0;
                    n_idx = '0;
                    n_bf = '1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // One entry a cycle; later entries win ties.
                if (r_idx == '0 || e_f <= r_bf) begin
                    n_bf = e_f; n_bcell = e_cell; n_best = r_idx[OW-1:0];
                end
                n_idx = r_idx + 1'b1;
                o_raddr = n_idx[OW-1:0];
                if (n_idx == r_cnt) begin
                    n_idx = (r_idx == '0 || e_f <= r_bf) ? CW'(r_idx) : CW'(r_best);
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                // Move entry idx+1 down to idx.
                if (r_idx + 1'b1 >= r_cnt) begin
                    n_cnt = r_cnt - 1'b1;
                    n_cur = AW'(32'(r_bcell[XW+YW-1:XW]) * GRID_W +
                                32'(r_bcell[XW-1:0]));
                    n_state = S_POP_RD;
                end else begin
                    o_raddr = OW'(r_idx + 1'b1);
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_we = 1'b1; o_waddr = r_idx[OW-1:0]; o_wdata = o_rdata;
                n_idx = r_idx + 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_POP_RD: begin
                c_raddr = r_cur;
                n_state = S_POP_CHK;
            end
            S_POP_CHK: begin
                if (rd_blk || rd_st == ST_CLOSED) begin
                    n_state = S_SCAN_RD;
                end else begin
                    c_we = 1'b1; c_waddr = r_cur;
                    c_wdata = {1'b0, ST_CLOSED, rd_par, rd_cost};
                    n_gcur = rd_cost;
                    if (r_cur == goal_idx) begin
                        n_res.found = 1'b1;
                        n_res.path_cost = rd_cost[9:0];
                        n_state = S_DONE;
                    end else begin
                        n_d = '0;
                        n_state = S_NB_RD;
                    end
                end
            end
            S_NB_RD: begin
                // Neighbours in the order up, left, right, down.
                if (r_d == 3'd4) begin
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_NB_CHK;
                    case (r_d[1:0])
                        2'd0: begin
                            n_nx = cur_x; n_ny = cur_y - 1'b1;
                            n_nb = r_cur - AW'(GRID_W);
                            if (cur_y == '0) n_state = S_NB_RD;
                        end
                        2'd1: begin
                            n_nx = cur_x - 1'b1; n_ny = cur_y;
                            n_nb = r_cur - 1'b1;
                            if (cur_x == '0) n_state = S_NB_RD;
                        end
                        2'd2: begin
                            n_nx = cur_x + 1'b1; n_ny = cur_y;
                            n_nb = r_cur + 1'b1;
                            if (32'(cur_x) == GRID_W - 1) n_state = S_NB_RD;
                        end
                        default: begin
                            n_nx = cur_x; n_ny = cur_y + 1'b1;
                            n_nb = r_cur + AW'(GRID_W);
                            if (32'(cur_y) == GRID_H - 1) n_state = S_NB_RD;
                        end
                    endcase
                    c_raddr = n_nb;
                    if (n_state == S_NB_RD) n_d = r_d + 1'b1;
                end
            end
            S_NB_CHK: begin
                n_d = r_d + 1'b1;
                n_state = S_NB_RD;
                if (!rd_blk && rd_st != ST_CLOSED && {1'b0, g1[10:0]} < {1'b0, rd_cost}
                    && g1 < 12'd1024) begin
                    c_we = 1'b1; c_waddr = r_nb;
                    c_wdata = {1'b0, ST_OPEN,
                               (r_d == 3'd0) ? DIR_DOWN :
                               (r_d == 3'd1) ? DIR_RIGHT :
                               (r_d == 3'd2) ? DIR_LEFT : DIR_UP,
                               g1[10:0]};
                    if (r_cnt < CW'(OPEN_DEPTH)) begin
                        o_we = 1'b1; o_waddr = r_cnt[OW-1:0];
                        o_wdata = {FW'(g1) + hx + hy, r_ny, r_nx};
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_RD_WAIT: begin
                c_raddr = cell_idx;
                n_state = S_RD_OUT;
            end
            S_RD_OUT: begin
                n_res.cell_cost = COST_INF;
                if (in_grid) begin
                    n_res.cell_status = rd_st;
                    n_res.cell_cost = rd_cost;
                    n_res.from_dir = rd_par;
                end
                n_strobe = 1'b1;
                n_state = S_IDLE;
            end
            S_DONE: begin
                if (r_cmd.cmd == CMD_OBSTACLE && in_grid) begin
                    c_we = 1'b1; c_waddr = cell_idx;
                    c_wdata = {1'b1, ST_OBSTACLE, DIR_NONE, COST_INF};
                end
                n_strobe = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_strobe   = r_strobe;
    assign o_res_beat = r_res;
endmodule
`default_nettype wire

/* bench/grid_astar_path_search_top_tb.sv */
`timescale 1ns / 1ps
module grid_astar_path_search_top_tb;
    import gaps_pkg::*;

    localparam int GW = 32;
    localparam int GH = 32;
    localparam int NCELLS = GW * GH;
    localparam int OPEN_MAX = 4096;
    localparam longint CYCLE_LIMIT = 60000000;
    localparam int N_RANDOM = 118;

    typedef struct {
        int f;
        int node;
    } t_frontier;

    // Keeps its own copy of the grid and predicts the result beat of each command.
    class astar_scoreboard;
        logic [10:0] g_cost[NCELLS];
        logic [1:0]  state[NCELLS];
        bit          blocked[NCELLS];
        logic [2:0]  parent[NCELLS];
        t_frontier   frontier[$];
        t_out_beat   awaited[$];
        int          errors;

        function void wipe_grid(bit keep_walls);
            for (int i = 0; i < NCELLS; i++) begin
                if (!(keep_walls && blocked[i])) begin
                    g_cost[i] = COST_INF;
                    state[i]  = ST_UNKNOWN;
                    parent[i] = DIR_NONE;
                    blocked[i] = 1'b0;
                end
            end
            frontier.delete();
        endfunction

        function void push_frontier(int f, int node);
            t_frontier e;
            if (frontier.size() >= OPEN_MAX) return;
            e.f = f;
            e.node = node;
            frontier.push_back(e);
        endfunction

        // Smallest f wins; on equal f the newest entry is taken.
        function int pop_frontier();
            int best;
            int node;
            best = 0;
            for (int i = 1; i < frontier.size(); i++)
                if (frontier[i].f <= frontier[best].f) best = i;
            node = frontier[best].node;
            frontier.delete(best);
            return node;
        endfunction

        function int span(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        function bit search(int sx, int sy, int gx, int gy, output int cost);
            int dxs[4] = '{0, -1, 1, 0};
            int dys[4] = '{-1, 0, 0, 1};
            logic [2:0] came[4] = '{DIR_DOWN, DIR_RIGHT, DIR_LEFT, DIR_UP};
            int target;
            int n;
            int x;
            int y;
            int nx;
            int ny;
            int m;
            int c;
            cost = 0;
            wipe_grid(1'b1);
            target = gy * GW + gx;
            if (blocked[sy * GW + sx]) return 1'b0;
            g_cost[sy * GW + sx] = 11'd0;
            push_frontier(span(gx, sx) + span(gy, sy), sy * GW + sx);
            while (frontier.size() > 0) begin
                n = pop_frontier();
                x = n % GW;
                y = n / GW;
                if (blocked[n] || state[n] == ST_CLOSED) continue;
                state[n] = ST_CLOSED;
                if (n == target) begin
                    cost = g_cost[n];
                    return 1'b1;
                end
                for (int d = 0; d < 4; d++) begin
                    nx = x + dxs[d];
                    ny = y + dys[d];
                    if (nx < 0 || ny < 0 || nx >= GW || ny >= GH) continue;
                    m = ny * GW + nx;
                    if (blocked[m] || state[m] == ST_CLOSED) continue;
                    c = g_cost[n] + 1;
                    if (c < g_cost[m] && c < COST_INF) begin
                        g_cost[m] = c;
                        state[m]  = ST_OPEN;
                        parent[m] = came[d];
                        push_frontier(c + span(gx, nx) + span(gy, ny), m);
                    end
                end
            end
            return 1'b0;
        endfunction

        // Called for every accepted command beat.
        function void note_command(t_in_beat b);
            t_out_beat r;
            int idx;
            int cost;
            r = '0;
            idx = b.cell_y * GW + b.cell_x;
            case (b.cmd)
                CMD_CLEAR: wipe_grid(1'b0);
                CMD_OBSTACLE: begin
                    blocked[idx] = 1'b1;
                    state[idx]   = ST_OBSTACLE;
                    g_cost[idx]  = COST_INF;
                    parent[idx]  = DIR_NONE;
                end
                CMD_SEARCH: begin
                    if (search(b.cell_x, b.cell_y, b.goal_x, b.goal_y, cost)) begin
                        r.found = 1'b1;
                        r.path_cost = cost[9:0];
                    end
                end
                default: begin
                    r.cell_status = state[idx];
                    r.cell_cost   = g_cost[idx];
                    r.from_dir    = parent[idx];
                end
            endcase
            awaited.push_back(r);
        endfunction

        // Called for every result beat seen on the strobe.
        function void check_result(t_out_beat got);
            t_out_beat exp;
            if (awaited.size() == 0) begin
                $error("result beat with nothing awaited: %h", got);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.found !== exp.found) begin
                $error("found: expected %0d, actual %0d", exp.found, got.found);
                errors++;
            end
            if (got.path_cost !== exp.path_cost) begin
                $error("path_cost: expected %0d, actual %0d", exp.path_cost, got.path_cost);
                errors++;
            end
            if (got.cell_status !== exp.cell_status) begin
                $error("cell_status: expected %0d, actual %0d",
                       exp.cell_status, got.cell_status);
                errors++;
            end
            if (got.cell_cost !== exp.cell_cost) begin
                $error("cell_cost: expected %0d, actual %0d", exp.cell_cost, got.cell_cost);
                errors++;
            end
            if (got.from_dir !== exp.from_dir) begin
                $error("from_dir: expected %0d, actual %0d", exp.from_dir, got.from_dir);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_beat  i_cmd_beat;
    logic      o_busy;
    logic      o_strobe;
    t_out_beat o_res_beat;

    astar_scoreboard grid_sb;
    longint cycles;
    int burst_left;

    grid_astar_path_search_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_cmd_beat (i_cmd_beat),
        .o_busy     (o_busy),
        .o_strobe   (o_strobe),
        .o_res_beat (o_res_beat)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result beats are checked as they appear; the watchdog ends a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) grid_sb.check_result(o_res_beat);
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Sends one command beat, opening a new burst after a random gap when due.
    task automatic send_cmd(input logic [1:0] cmd, input int cx, input int cy,
                            input int gx, input int gy);
        t_in_beat b;
        int gap;
        b.cmd = cmd;
        b.cell_x = cx[4:0];
        b.cell_y = cy[4:0];
        b.goal_x = gx[4:0];
        b.goal_y = gy[4:0];
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_start <= 1'b1;
        i_cmd_beat <= b;
        do @(posedge i_clk); while (o_busy);
        grid_sb.note_command(b);
    endtask

    function automatic int near(int v);
        int r;
        r = v + $urandom_range(0, 12) - 6;
        if (r < 0) r = 0;
        if (r > 31) r = 31;
        return r;
    endfunction

    initial begin
        int sent;
        int walls;
        int sx;
        int sy;
        int gx;
        int gy;
        int waited;
        grid_sb = new();
        grid_sb.wipe_grid(1'b0);
        cycles = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_cmd_beat <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, obstacles, blocked start and target, trivial search.
        send_cmd(CMD_READ, 0, 0, 0, 0);
        send_cmd(CMD_READ, 31, 31, 31, 31);
        send_cmd(CMD_SEARCH, 31, 31, 31, 31);
        send_cmd(CMD_READ, 31, 31, 0, 0);
        send_cmd(CMD_SEARCH, 0, 0, 31, 31);
        send_cmd(CMD_READ, 31, 31, 0, 0);
        send_cmd(CMD_READ, 1, 0, 0, 0);
        send_cmd(CMD_OBSTACLE, 5, 5, 0, 0);
        send_cmd(CMD_OBSTACLE, 5, 5, 31, 31);
        send_cmd(CMD_READ, 5, 5, 0, 0);
        send_cmd(CMD_SEARCH, 5, 5, 6, 6);
        send_cmd(CMD_SEARCH, 2, 5, 8, 5);
        send_cmd(CMD_READ, 5, 4, 0, 0);
        send_cmd(CMD_READ, 5, 6, 0, 0);
        send_cmd(CMD_READ, 8, 5, 0, 0);
        // A blocked target drives a sweep over the whole reachable grid.
        send_cmd(CMD_SEARCH, 4, 5, 5, 5);
        send_cmd(CMD_READ, 31, 0, 0, 0);
        send_cmd(CMD_READ, 0, 31, 0, 0);
        send_cmd(CMD_CLEAR, 31, 31, 31, 31);
        send_cmd(CMD_READ, 5, 5, 0, 0);
        send_cmd(CMD_SEARCH, 31, 0, 0, 31);
        send_cmd(CMD_READ, 0, 31, 0, 0);

        // Random: walls near a start, a search to a nearby target, reads on the way.
        sent = 0;
        walls = 0;
        while (sent < N_RANDOM) begin
            if (walls > 50 || $urandom_range(0, 9) == 0) begin
                send_cmd(CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 31), $urandom_range(0, 31));
                sent++;
                walls = 0;
            end
            sx = $urandom_range(0, 31);
            sy = $urandom_range(0, 31);
            gx = near(sx);
            gy = near(sy);
            repeat ($urandom_range(0, 5)) begin
                send_cmd(CMD_OBSTACLE, near(sx), near(sy),
                         $urandom_range(0, 31), $urandom_range(0, 31));
                sent++;
                walls++;
            end
            if ($urandom_range(0, 7) == 0) begin
                gx = $urandom_range(0, 31);
                gy = sy;
            end
            send_cmd(CMD_SEARCH, sx, sy, gx, gy);
            sent++;
            repeat ($urandom_range(1, 3)) begin
                send_cmd(CMD_READ, near(sx), near(sy),
                         $urandom_range(0, 31), $urandom_range(0, 31));
                sent++;
            end
        end
        i_start <= 1'b0;

        // Drain: every command returns exactly one beat.
        waited = 0;
        while (grid_sb.awaited.size() > 0 && waited < 5000000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (grid_sb.errors == 0 && grid_sb.awaited.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

/* grid_astar_path_search_top.f */
rtl/gaps_pkg.sv
rtl/gaps_ram.sv
rtl/grid_astar_path_search_top.sv
bench/grid_astar_path_search_top_tb.sv
